[hdl/lma_pkg.sv]
`default_nettype none
package lma_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = 18;
    localparam int MAX_LAGS_DEF = 16;
    localparam int LAG_BITS     = 5;
    localparam int FUNC_BITS    = 2;
    localparam int CFG_BITS     = 5;
    localparam int SQ_BITS      = 2 * SAMPLE_BITS;
    localparam int SUM_BITS     = 31;
    localparam int SUMSQ_BITS   = 41;
    localparam int CUBE_BITS    = 53;
    localparam int FOURTH_BITS  = 63;
    localparam int PAIR_BITS    = 31;
    localparam int PROD_BITS    = 41;

    localparam logic [0:0] CFG_EXT_ENABLE = 1'b0;
    localparam logic [0:0] CFG_NUM_LAGS   = 1'b1;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_REPORT = 2'd2
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_POW,
        S_ACC,
        S_LAG,
        S_PUSH,
        S_DRAIN,
        S_REP_RD,
        S_REP_OUT
    } t_state;

    typedef struct packed {
        logic                ld_x;
        logic                ovf;
        logic                clr_all;
        logic                sq;
        logic                pow;
        logic                acc;
        logic                walk;
        logic                rd;
        logic                push;
        logic                out_ld;
        logic                out_last;
        logic                out_none;
        logic [LAG_BITS-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic                full;
        logic                ovf;
        logic                out_free;
        logic [LAG_BITS-1:0] fill;
        logic [LAG_BITS-1:0] nl;
    } t_sts;

endpackage
`default_nettype wire

[hdl/lma_if.sv]
`default_nettype none
interface lma_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [lma_pkg::FUNC_BITS-1:0]          func;
    logic signed [lma_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink (input valid, input func, input sample, output ready);
endinterface

interface lma_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [4:0]                             lag_index;
    logic signed [31:0]                     lag_pair_sum;
    logic signed [41:0]                     lag_product_sum;
    logic [17:0]                            count;
    logic signed [29:0]                     total;
    logic [40:0]                            total_sq;
    logic signed [52:0]                     total_cube;
    logic [62:0]                            total_fourth;
    logic signed [11:0]                     minimum;
    logic signed [11:0]                     maximum;
    logic                                   saturated;
    logic                                   last;

    modport source (output valid, output lag_index, output lag_pair_sum,
                    output lag_product_sum, output count, output total, output total_sq,
                    output total_cube, output total_fourth, output minimum,
                    output maximum, output saturated, output last, input ready);
    modport sink (input valid, input lag_index, input lag_pair_sum,
                  input lag_product_sum, input count, input total, input total_sq,
                  input total_cube, input total_fourth, input minimum,
                  input maximum, input saturated, input last, output ready);
endinterface
`default_nettype wire

[hdl/lma_ctrl.sv]
`default_nettype none
module lma_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [lma_pkg::FUNC_BITS-1:0] i_func,
    output logic                               o_ready,
    input  wire lma_pkg::t_sts                 i_sts,
    output lma_pkg::t_cmd                      o_cmd
);

    lma_pkg::t_state                r_state, n_state;
    logic [lma_pkg::LAG_BITS-1:0]   r_k, n_k;
    logic                           w_take;
    logic                           w_rep_last;

    assign w_take     = i_valid && (r_state == lma_pkg::S_IDLE);
    assign w_rep_last = (i_sts.nl == '0) || (r_k == i_sts.nl - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lma_pkg::S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            lma_pkg::S_IDLE: begin
                if (w_take) begin
                    case (lma_pkg::t_func'(i_func))
                        lma_pkg::FUNC_SAMPLE: begin
                            if (!i_sts.full) n_state = lma_pkg::S_SQ;
                        end
                        lma_pkg::FUNC_REPORT: begin
                            n_k = '0;
                            n_state = (i_sts.nl == '0) ? lma_pkg::S_REP_OUT
                                                       : lma_pkg::S_REP_RD;
                        end
                        default: n_state = lma_pkg::S_IDLE;
                    endcase
                end
            end
            lma_pkg::S_SQ:  n_state = lma_pkg::S_POW;
            lma_pkg::S_POW: n_state = lma_pkg::S_ACC;
            lma_pkg::S_ACC: begin
                n_k = '0;
                if (i_sts.nl == '0)        n_state = lma_pkg::S_IDLE;
                else if (i_sts.fill == '0) n_state = lma_pkg::S_PUSH;
                else                       n_state = lma_pkg::S_LAG;
            end
            lma_pkg::S_LAG: begin
                if (r_k == i_sts.fill - 1'b1) n_state = lma_pkg::S_PUSH;
                else                          n_k = r_k + 1'b1;
            end
            lma_pkg::S_PUSH:   n_state = lma_pkg::S_DRAIN;
            lma_pkg::S_DRAIN:  n_state = lma_pkg::S_IDLE;
            lma_pkg::S_REP_RD: n_state = lma_pkg::S_REP_OUT;
            lma_pkg::S_REP_OUT: begin
                if (i_sts.out_free) begin
                    if (w_rep_last) begin
                        n_state = lma_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = lma_pkg::S_REP_RD;
                    end
                end
            end
            default: n_state = lma_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd     = '0;
        o_cmd.idx = r_k;
        o_ready   = (r_state == lma_pkg::S_IDLE);
        case (r_state)
            lma_pkg::S_IDLE: begin
                if (w_take) begin
                    case (lma_pkg::t_func'(i_func))
                        lma_pkg::FUNC_SAMPLE: begin
                            o_cmd.ld_x = !i_sts.full;
                            o_cmd.ovf  = i_sts.full;
                        end
                        lma_pkg::FUNC_CLEAR: o_cmd.clr_all = 1'b1;
                        default: o_cmd.clr_all = 1'b0;
                    endcase
                end
            end
            lma_pkg::S_SQ:  o_cmd.sq  = 1'b1;
            lma_pkg::S_POW: o_cmd.pow = 1'b1;
            lma_pkg::S_ACC: o_cmd.acc = 1'b1;
            lma_pkg::S_LAG: begin
                o_cmd.walk = 1'b1;
                o_cmd.rd   = 1'b1;
            end
            lma_pkg::S_PUSH:   o_cmd.push = 1'b1;
            lma_pkg::S_REP_RD: o_cmd.rd   = 1'b1;
            lma_pkg::S_REP_OUT: begin
                o_cmd.out_ld   = i_sts.out_free;
                o_cmd.out_last = w_rep_last;
                o_cmd.out_none = (i_sts.nl == '0);
            end
            default: o_cmd.ld_x = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

[hdl/lma_dp.sv]
`default_nettype none
module lma_dp #(
    parameter int MAX_LAGS = lma_pkg::MAX_LAGS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic signed [lma_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                   i_cfg_we,
    input  wire logic [0:0]                             i_cfg_idx,
    input  wire logic [lma_pkg::CFG_BITS-1:0]           i_cfg_wdata,
    input  wire lma_pkg::t_cmd                          i_cmd,
    output lma_pkg::t_sts                               o_sts,
    lma_out_if.source                                   o_out
);

    localparam int LW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
    localparam int SB = lma_pkg::SAMPLE_BITS;
    localparam int QB = lma_pkg::SQ_BITS;
    localparam int LB = lma_pkg::LAG_BITS;

    logic                                 r_ext;
    logic [LB-1:0]                        r_nl;
    logic signed [SB-1:0]                 r_x;
    logic [QB-1:0]                        r_sq;
    logic signed [QB+SB:0]                r_cube;
    logic [2*QB-1:0]                      r_four;
    logic [lma_pkg::COUNT_BITS-1:0]       r_cnt;
    logic signed [lma_pkg::SUM_BITS-1:0]  r_sum;
    logic [lma_pkg::SUMSQ_BITS-1:0]       r_sumsq;
    logic signed [lma_pkg::CUBE_BITS-1:0] r_sumcube;
    logic [lma_pkg::FOURTH_BITS-1:0]      r_sumfour;
    logic signed [SB-1:0]                 r_min, r_max;
    logic                                 r_ovf;

    logic signed [SB-1:0]                 r_dly [MAX_LAGS];
    logic [LW-1:0]                        r_wp;
    logic [LB-1:0]                        r_fill;

    logic signed [lma_pkg::PAIR_BITS-1:0] r_pair [MAX_LAGS];
    logic signed [lma_pkg::PROD_BITS-1:0] r_prod [MAX_LAGS];
    logic [MAX_LAGS-1:0]                  r_vld;

    logic signed [SB-1:0]                 r_d1;
    logic signed [lma_pkg::PAIR_BITS-1:0] r_rp;
    logic signed [lma_pkg::PROD_BITS-1:0] r_rq;
    logic                                 r_rv;
    logic                                 r_s1;
    logic [LW-1:0]                        r_a1;
    logic signed [lma_pkg::PAIR_BITS-1:0] r_pa2;
    logic signed [lma_pkg::PROD_BITS-1:0] r_pq2;
    logic signed [QB-1:0]                 r_pr2;
    logic                                 r_s2;
    logic [LW-1:0]                        r_a2;

    logic                                 r_ov;

    logic                                 w_lag_clr;
    logic [LW:0]                          w_dsum;
    logic [LW-1:0]                        w_didx;
    logic [LW-1:0]                        w_aidx;
    logic signed [lma_pkg::PAIR_BITS-1:0] w_rp;
    logic signed [lma_pkg::PROD_BITS-1:0] w_rq;

    assign w_lag_clr = i_cmd.clr_all || (i_cfg_we && i_cfg_idx == lma_pkg::CFG_NUM_LAGS);
    assign w_aidx    = LW'(i_cmd.idx);
    // sample idx+1 steps back sits idx+1 slots behind the write pointer
    assign w_dsum    = {1'b0, r_wp} + (LW+1)'(MAX_LAGS - 1) - (LW+1)'(i_cmd.idx);
    assign w_didx    = (w_dsum >= (LW+1)'(MAX_LAGS)) ? LW'(w_dsum - (LW+1)'(MAX_LAGS))
                                                     : LW'(w_dsum);
    assign w_rp      = r_rv ? r_rp : '0;
    assign w_rq      = r_rv ? r_rq : '0;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext  <= 1'b0;
            r_nl   <= '0;
            r_wp   <= '0;
            r_fill <= '0;
            r_vld  <= '0;
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == lma_pkg::CFG_EXT_ENABLE) r_ext <= i_cfg_wdata[0];
            if (i_cfg_we && i_cfg_idx == lma_pkg::CFG_NUM_LAGS) begin
                r_nl <= (32'(i_cfg_wdata) > MAX_LAGS) ? LB'(MAX_LAGS) : i_cfg_wdata;
            end
            r_s1 <= i_cmd.walk;
            r_s2 <= r_s1;
            if (w_lag_clr) begin
                r_vld  <= '0;
                r_fill <= '0;
            end else begin
                if (r_s2) r_vld[r_a2] <= 1'b1;
                if (i_cmd.push) begin
                    r_wp <= (r_wp == LW'(MAX_LAGS - 1)) ? '0 : r_wp + 1'b1;
                    if (r_fill < r_nl) r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.out_ld)     r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    // running moments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
            r_sumcube <= '0;
            r_sumfour <= '0;
            r_min     <= {1'b0, {(SB-1){1'b1}}};
            r_max     <= {1'b1, {(SB-1){1'b0}}};
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.ovf) r_ovf <= 1'b1;
            if (i_cmd.acc) begin
                r_cnt   <= r_cnt + 1'b1;
                r_sum   <= r_sum + lma_pkg::SUM_BITS'(r_x);
                r_sumsq <= r_sumsq + lma_pkg::SUMSQ_BITS'(r_sq);
                if (r_x < r_min) r_min <= r_x;
                if (r_x > r_max) r_max <= r_x;
                if (r_ext) begin
                    r_sumcube <= r_sumcube + lma_pkg::CUBE_BITS'(r_cube);
                    r_sumfour <= r_sumfour + lma_pkg::FOURTH_BITS'(r_four);
                end
            end
        end
    end

    // power products
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x) r_x <= i_sample;
        if (i_cmd.sq)   r_sq <= QB'(r_x * r_x);
        if (i_cmd.pow) begin
            r_cube <= r_x * $signed({1'b0, r_sq});
            r_four <= r_sq * r_sq;
        end
    end

    // delay line and lag sum memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_dly[r_wp] <= r_x;
        if (r_s2) begin
            r_pair[r_a2] <= r_pa2;
            r_prod[r_a2] <= r_pq2 + lma_pkg::PROD_BITS'(r_pr2);
        end
        if (i_cmd.rd) begin
            r_d1 <= r_dly[w_didx];
            r_rp <= r_pair[w_aidx];
            r_rq <= r_prod[w_aidx];
            r_rv <= r_vld[w_aidx];
            r_a1 <= w_aidx;
        end
        r_pa2 <= w_rp + lma_pkg::PAIR_BITS'(r_x) + lma_pkg::PAIR_BITS'(r_d1);
        r_pq2 <= w_rq;
        r_pr2 <= QB'(r_x * r_d1);
        r_a2  <= r_a1;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_out.lag_index       <= i_cmd.out_none ? '0 : i_cmd.idx + 1'b1;
            o_out.lag_pair_sum    <= i_cmd.out_none ? '0 : 32'(w_rp);
            o_out.lag_product_sum <= i_cmd.out_none ? '0 : 42'(w_rq);
            o_out.count           <= r_cnt;
            o_out.total           <= 30'(r_sum);
            o_out.total_sq        <= r_sumsq;
            o_out.total_cube      <= r_sumcube;
            o_out.total_fourth    <= r_sumfour;
            o_out.minimum         <= r_min;
            o_out.maximum         <= r_max;
            o_out.saturated       <= r_ovf;
            o_out.last            <= i_cmd.out_last;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_sts.full     = (r_cnt == '1);
    assign o_sts.ovf      = r_ovf;
    assign o_sts.out_free = !r_ov || o_out.ready;
    assign o_sts.fill     = r_fill;
    assign o_sts.nl       = r_nl;

endmodule
`default_nettype wire

[hdl/lagged_moment_accumulator.sv]
// Running moments and lagged autocorrelation sums over 12-bit signed samples.
// Each transfer on i_in carries a function code: sample accumulates count, sum,
// sum of squares, min and max (plus cubes and fourth powers when ext_enable is
// set) and the per-lag pair and product sums for lags 1..num_lags; clear zeroes
// all accumulators and empties the delay line; report emits one result per lag on
// o_out (or a single lag-0 result when num_lags is 0), last marking the final
// one. With lags in use a sample runs through the states in order: the accept
// loads the sample, S_SQ forms the square, S_POW the cube and fourth power,
// S_ACC accumulates, S_LAG walks the lag sum memory over each filled delay tap
// (up to num_lags), and S_PUSH and S_DRAIN push the delay line and retire the
// last write. With num_lags at 0 the walk and the push are skipped. Clear and
// code 3 complete at the accept; a report accepts, then reads and presents each
// result in turn, waiting while the consumer stalls. Once the count reaches its
// all-ones value further samples are dropped and saturated is set. Writing
// num_lags clamps it to MAX_LAGS and empties the delay line and lag sums; write
// configuration only while the block is idle.
`default_nettype none
module lagged_moment_accumulator #(
    parameter int MAX_LAGS = lma_pkg::MAX_LAGS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    lma_in_if.sink                                   i_in,
    lma_out_if.source                                o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [0:0]                          i_cfg_idx,
    input  wire logic [lma_pkg::CFG_BITS-1:0]        i_cfg_wdata
);

    lma_pkg::t_cmd w_cmd;
    lma_pkg::t_sts w_sts;

    // sequencing: accept, power steps, lag walk, report
    lma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .o_ready (i_in.ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // accumulators, delay line, lag memories and the result register
    lma_dp #(
        .MAX_LAGS (MAX_LAGS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_in.sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // fill never runs past the lags in use
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.fill <= w_sts.nl)
        else $error("delay fill exceeds num_lags");

    // saturated flag only with a full count
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.ovf |-> w_sts.full)
        else $error("saturated without full count");

    // a clear transfer drops the saturated flag
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.func == lma_pkg::FUNC_CLEAR) |=> !w_sts.ovf)
        else $error("clear left saturated set");

    // a result is loaded only into a free output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> (!o_out.valid || o_out.ready))
        else $error("result overwrote a pending transfer");
`endif

endmodule
`default_nettype wire
